// ===== hw/rtl/msrp_pkg.sv =====
// Package for the masked softmax region probability core.
// Holds the item and result words, the operation codes and the engine states.
// No dependencies.
package msrp_pkg;

	localparam logic [1:0] MODE_COV  = 2'd0;
	localparam logic [1:0] MODE_MASK = 2'd1;
	localparam logic [1:0] MODE_BETA = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	localparam logic CFG_CELLS  = 1'b0;
	localparam logic CFG_LAYERS = 1'b1;

	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [14:0] EXP_A     = 15'd21512;
	localparam logic [12:0] EXP_B     = 13'd5128;

	typedef enum logic [1:0] {
		OP_COV,
		OP_MASK,
		OP_BETA,
		OP_DRAW
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [9:0]  cell_index;
		logic [1:0]  layer_index;
		logic [2:0]  cov_index;
		logic [15:0] cov_value;
		logic        cov_valid;
		logic [15:0] mask_value;
		logic [15:0] beta_value;
	} item_t;

	typedef struct packed {
		logic [1:0]  out_layer;
		logic [15:0] probability;
		logic        no_valid;
		logic        last;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRD_RD,
		ST_PRD_MUL,
		ST_PRD_ACC,
		ST_PRD_WR,
		ST_EXP_RD,
		ST_EXP_D,
		ST_EXP_Y,
		ST_EXP_P1,
		ST_EXP_P2,
		ST_EXP_ACC,
		ST_EXP_MSK,
		ST_DIV_CHK,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage

// ===== hw/rtl/msrp_front.sv =====
// Front of the core: accepts input words, classifies them and queues them.
// Depends on msrp_pkg.
module msrp_front import msrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  mode,
	input  logic [9:0]  cell_index,
	input  logic [1:0]  layer_index,
	input  logic [2:0]  cov_index,
	input  logic [15:0] cov_value,
	input  logic        cov_valid,
	input  logic [15:0] mask_value,
	input  logic [15:0] beta_value,
	input  logic        last_beta,
	output logic        item_valid,
	input  logic        item_ready,
	output item_t       item
);

	item_t      fifo_q [2];
	logic [1:0] cnt_q;
	logic       wp_q;
	logic       rp_q;
	logic       keep;
	op_t        op;
	logic       wr;
	logic       rd;

	always_comb begin
		keep = 1'b1;
		op = OP_COV;
		unique case (mode)
			MODE_COV: op = OP_COV;
			MODE_MASK: op = OP_MASK;
			MODE_BETA: op = last_beta ? OP_DRAW : OP_BETA;
			default: keep = 1'b0;
		endcase
	end

	assign full = (cnt_q == 2'd2);
	assign wr = push && !full && keep;
	assign item_valid = (cnt_q != 2'd0);
	assign rd = item_valid && item_ready;
	assign item = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			fifo_q[wp_q] <= '{op, cell_index, layer_index, cov_index, cov_value, cov_valid,
				mask_value, beta_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule

// ===== hw/rtl/msrp_outq.sv =====
// Two-entry result queue between the engine and the result ports.
// Depends on msrp_pkg.
module msrp_outq import msrp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_push,
	output logic    res_full,
	input  result_t res_in,
	input  logic    pop,
	output logic    empty,
	output result_t res_out
);

	result_t    q_q [2];
	logic [1:0] cnt_q;
	logic       wp_q;
	logic       rp_q;
	logic       wr;
	logic       rd;

	assign res_full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign wr = res_push && !res_full;
	assign rd = pop && !empty;
	assign res_out = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) q_q[wp_q] <= res_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule

// ===== hw/rtl/msrp_back.sv =====
// Back of the core: the stores, the configuration registers and the draw sequencer.
// Depends on msrp_pkg; fed by msrp_front, drains into msrp_outq.
module msrp_back import msrp_pkg::*; #(
	parameter int MAX_CELLS  = 1024,
	parameter int MAX_LAYERS = 4,
	parameter int MAX_COVS   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	input  logic        cfg_valid,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data,
	output logic        res_push,
	input  logic        res_full,
	output result_t     res
);

	localparam int CIW = $clog2(MAX_CELLS);
	localparam int CNW = $clog2(MAX_CELLS + 1);
	localparam int LIW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
	localparam int LNW = $clog2(MAX_LAYERS + 1);
	localparam int CW = (MAX_COVS > 1) ? $clog2(MAX_COVS) : 1;
	localparam int CDEPTH = MAX_CELLS * MAX_LAYERS * MAX_COVS;
	localparam int CAW = $clog2(CDEPTH);
	localparam int MDEPTH = MAX_CELLS * MAX_LAYERS;
	localparam int MAW = $clog2(MDEPTH);
	localparam int WW = 33 + CW;
	localparam int TW = 17 + CNW;
	localparam int MW = 33 + CNW;
	localparam logic [CAW-1:0] LSTEP = CAW'(MAX_COVS);
	localparam logic [CAW-1:0] CSTEP = CAW'(MAX_LAYERS * MAX_COVS);
	localparam logic [MAW-1:0] MSTEP = MAW'(MAX_LAYERS);
	localparam int CELLS_RST = (MAX_CELLS < 1024) ? MAX_CELLS : 1024;
	localparam int LAYERS_RST = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;

	logic [16:0]   cov_mem [CDEPTH];
	logic [15:0]   mask_mem [MDEPTH];
	logic [WW:0]   pred_mem [MAX_CELLS];
	logic [15:0]   beta_q [MAX_COVS];

	state_t        state_q;
	state_t        state_n;
	logic [CNW-1:0] ncells_q;
	logic [LNW-1:0] nlayers_q;
	logic [CW-1:0] jlast_q;
	logic [CW-1:0] j_q;
	logic [CIW-1:0] c_q;
	logic [LIW-1:0] k_q;
	logic [CAW-1:0] lbase_q;
	logic [CAW-1:0] cbase_q;
	logic [MAW-1:0] mbase_q;
	logic [16:0]   cov_rd_q;
	logic [15:0]   mask_rd_q;
	logic [WW:0]   pred_rd_q;
	logic signed [15:0] beta_rd_q;
	logic signed [31:0] prod_q;
	logic signed [WW-1:0] acc_q;
	logic          okacc_q;
	logic signed [WW-1:0] mx_q;
	logic          any_q;
	logic          any_n;
	logic          okc_q;
	logic          big_q;
	logic [23:0]   d_q;
	logic [24:0]   y_q;
	logic          zero_q;
	logic [3:0]    n_q;
	logic [29:0]   ff_q;
	logic [14:0]   af_q;
	logic [15:0]   e_q;
	logic [31:0]   em_q;
	logic [TW-1:0] total_q;
	logic [MW-1:0] masked_q;
	logic [MW-1:0] rem_q;
	logic [MW-2:0] dsor_q;
	logic [3:0]    bit_q;
	logic [15:0]   quo_q;
	logic [15:0]   p_q;
	logic          nv_q;

	logic          in_go;
	logic          cell_last;
	logic          layer_last;
	logic          j_last;
	logic          in_cov_ok;
	logic          in_addr_ok;
	logic [CW-1:0] in_cov;
	logic [CAW-1:0] cov_waddr;
	logic [MAW-1:0] mask_waddr;
	logic          better;
	logic signed [WW:0] diff;
	logic [40:0]   yprod;
	logic [4:0]    n_full;
	logic [14:0]   f_val;
	logic [42:0]   bprod;
	logic [16:0]   e_full;
	logic [MW-1:0] sat_lim;
	logic [MW-1:0] dsor_ext;

	assign in_go = item_valid && item_ready;
	assign in_cov_ok = 32'(item.cov_index) < MAX_COVS;
	assign in_addr_ok = (32'(item.cell_index) < MAX_CELLS) && (32'(item.layer_index) < MAX_LAYERS);
	assign in_cov = CW'(32'(item.cov_index));
	assign cov_waddr = CAW'((32'(item.cell_index) * MAX_LAYERS + 32'(item.layer_index))
		* MAX_COVS + 32'(item.cov_index));
	assign mask_waddr = MAW'(32'(item.cell_index) * MAX_LAYERS + 32'(item.layer_index));
	assign cell_last = (c_q == CIW'(32'(ncells_q) - 1));
	assign layer_last = (32'(k_q) == 32'(nlayers_q) - 1);
	assign j_last = (j_q == jlast_q);
	assign better = okacc_q && (!any_q || (acc_q > mx_q));
	assign any_n = any_q || better;
	assign diff = {mx_q[WW-1], mx_q} - $signed(pred_rd_q[WW:0] & {1'b0, {WW{1'b1}}}
		| {pred_rd_q[WW-1], {WW{1'b0}}});
	assign yprod = 41'(d_q) * 41'(LOG2E_Q16);
	assign n_full = y_q[24:20];
	assign f_val = y_q[19:5];
	assign bprod = 43'(ff_q) * 43'(EXP_B);
	assign e_full = 17'd32768 - 17'(af_q) + 17'(bprod[42:30]);
	assign sat_lim = {total_q, 16'd0};
	assign dsor_ext = {1'b0, dsor_q};

	always_ff @(posedge clk) begin
		if (in_go && item.op == OP_COV && in_addr_ok && in_cov_ok) begin
			cov_mem[cov_waddr] <= {item.cov_valid, item.cov_value};
		end
		cov_rd_q <= cov_mem[cbase_q + CAW'(j_q)];
	end

	always_ff @(posedge clk) begin
		if (in_go && item.op == OP_MASK && in_addr_ok) begin
			mask_mem[mask_waddr] <= item.mask_value;
		end
		mask_rd_q <= mask_mem[mbase_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PRD_WR) pred_mem[c_q] <= {okacc_q, acc_q};
		pred_rd_q <= pred_mem[c_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ncells_q <= CNW'(CELLS_RST);
			nlayers_q <= LNW'(LAYERS_RST);
			for (int i = 0; i < MAX_COVS; i++) beta_q[i] <= 16'd0;
		end else begin
			state_q <= state_n;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_CELLS: begin
						if (cfg_data == 11'd0) ncells_q <= CNW'(1);
						else if (32'(cfg_data) > MAX_CELLS) ncells_q <= CNW'(MAX_CELLS);
						else ncells_q <= CNW'(32'(cfg_data));
					end
					default: begin
						if (cfg_data[2:0] == 3'd0) nlayers_q <= LNW'(1);
						else if (32'(cfg_data[2:0]) > MAX_LAYERS) nlayers_q <= LNW'(MAX_LAYERS);
						else nlayers_q <= LNW'(32'(cfg_data[2:0]));
					end
				endcase
			end
			if (in_go && (item.op == OP_BETA || item.op == OP_DRAW) && in_cov_ok) begin
				beta_q[in_cov] <= item.beta_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				jlast_q <= in_cov_ok ? in_cov : CW'(MAX_COVS - 1);
				k_q <= '0;
				lbase_q <= '0;
				cbase_q <= '0;
				mbase_q <= '0;
				c_q <= '0;
				j_q <= '0;
				acc_q <= '0;
				okacc_q <= 1'b1;
				any_q <= 1'b0;
			end
			ST_PRD_RD: beta_rd_q <= $signed(beta_q[j_q]);
			ST_PRD_MUL: begin
				prod_q <= $signed(cov_rd_q[15:0]) * beta_rd_q;
				if (!cov_rd_q[16]) okacc_q <= 1'b0;
			end
			ST_PRD_ACC: begin
				acc_q <= acc_q + WW'(prod_q);
				if (!j_last) j_q <= j_q + CW'(1);
			end
			ST_PRD_WR: begin
				if (better) mx_q <= acc_q;
				any_q <= any_n;
				acc_q <= '0;
				okacc_q <= 1'b1;
				j_q <= '0;
				total_q <= '0;
				masked_q <= '0;
				p_q <= 16'd0;
				nv_q <= !any_n;
				if (cell_last) c_q <= '0;
				else begin
					c_q <= c_q + CIW'(1);
					cbase_q <= cbase_q + CSTEP;
				end
			end
			ST_EXP_RD: ;
			ST_EXP_D: begin
				okc_q <= pred_rd_q[WW];
				big_q <= |diff[WW:24];
				d_q <= diff[23:0];
			end
			ST_EXP_Y: y_q <= yprod[40:16];
			ST_EXP_P1: begin
				zero_q <= big_q || !okc_q || (n_full >= 5'd16);
				n_q <= n_full[3:0];
				ff_q <= 30'(f_val) * 30'(f_val);
				af_q <= 15'((30'(f_val) * 30'(EXP_A)) >> 15);
			end
			ST_EXP_P2: e_q <= zero_q ? 16'd0 : 16'(e_full >> n_q);
			ST_EXP_ACC: begin
				total_q <= total_q + TW'(e_q);
				em_q <= 32'(e_q) * 32'(mask_rd_q);
			end
			ST_EXP_MSK: begin
				masked_q <= masked_q + MW'(em_q);
				if (!cell_last) begin
					c_q <= c_q + CIW'(1);
					mbase_q <= mbase_q + MSTEP;
				end
			end
			ST_DIV_CHK: begin
				rem_q <= masked_q;
				dsor_q <= {total_q, 15'd0};
				bit_q <= 4'd15;
				quo_q <= 16'd0;
				if (masked_q >= sat_lim) p_q <= 16'hFFFF;
			end
			ST_DIV: begin
				if (rem_q >= dsor_ext) begin
					rem_q <= rem_q - dsor_ext;
					quo_q[bit_q] <= 1'b1;
				end
				if (bit_q == 4'd0) begin
					p_q <= (rem_q >= dsor_ext) ? (quo_q | 16'd1) : quo_q;
				end
				dsor_q <= dsor_q >> 1;
				bit_q <= bit_q - 4'd1;
			end
			ST_EMIT: begin
				if (!res_full) begin
					k_q <= k_q + LIW'(1);
					lbase_q <= lbase_q + LSTEP;
					cbase_q <= lbase_q + LSTEP;
					mbase_q <= MAW'(32'(k_q) + 1);
					c_q <= '0;
					j_q <= '0;
					acc_q <= '0;
					okacc_q <= 1'b1;
					any_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (in_go && item.op == OP_DRAW) state_n = ST_PRD_RD;
			ST_PRD_RD: state_n = ST_PRD_MUL;
			ST_PRD_MUL: state_n = ST_PRD_ACC;
			ST_PRD_ACC: state_n = j_last ? ST_PRD_WR : ST_PRD_RD;
			ST_PRD_WR: begin
				if (!cell_last) state_n = ST_PRD_RD;
				else state_n = any_n ? ST_EXP_RD : ST_EMIT;
			end
			ST_EXP_RD: state_n = ST_EXP_D;
			ST_EXP_D: state_n = ST_EXP_Y;
			ST_EXP_Y: state_n = ST_EXP_P1;
			ST_EXP_P1: state_n = ST_EXP_P2;
			ST_EXP_P2: state_n = ST_EXP_ACC;
			ST_EXP_ACC: state_n = ST_EXP_MSK;
			ST_EXP_MSK: state_n = cell_last ? ST_DIV_CHK : ST_EXP_RD;
			ST_DIV_CHK: state_n = (masked_q >= sat_lim) ? ST_EMIT : ST_DIV;
			ST_DIV: if (bit_q == 4'd0) state_n = ST_EMIT;
			ST_EMIT: begin
				if (!res_full) state_n = layer_last ? ST_IDLE : ST_PRD_RD;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready = (state_q == ST_IDLE);
		res_push = (state_q == ST_EMIT);
		res.out_layer = 2'(32'(k_q));
		res.probability = p_q;
		res.no_valid = nv_q;
		res.last = layer_last;
	end

endmodule

// ===== hw/rtl/masked_softmax_region_probability_core.sv =====
// Masked softmax region probability core, top level.
// Instantiates msrp_front, msrp_back and msrp_outq; depends on msrp_pkg.
// The back engine takes covariate and mask writes and beta loads only while idle.
// A last_beta word starts a draw that holds off input; each layer in use runs the
// predictor walk over the cells (one covariate store read and one 16 x 16 multiply
// per covariate), then, if any cell is valid, the exponential walk and the divider
// (skipped when the quotient saturates), then hands over the result word, waiting
// while the result queue is full. The stores need no clearing pass after reset.
module masked_softmax_region_probability_core import msrp_pkg::*; #(
	parameter int MAX_CELLS  = 1024,
	parameter int MAX_LAYERS = 4,
	parameter int MAX_COVS   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  mode,
	input  logic [9:0]  cell_index,
	input  logic [1:0]  layer_index,
	input  logic [2:0]  cov_index,
	input  logic signed [15:0] cov_value,
	input  logic        cov_valid,
	input  logic [15:0] mask_value,
	input  logic signed [15:0] beta_value,
	input  logic        last_beta,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  out_layer,
	output logic [15:0] probability,
	output logic        no_valid,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);

	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    res_push;
	logic    res_full;
	result_t res_in;
	result_t res_out;

	assign cfg_ready = 1'b1;

	msrp_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .mode(mode),
		.cell_index(cell_index), .layer_index(layer_index), .cov_index(cov_index),
		.cov_value(cov_value), .cov_valid(cov_valid), .mask_value(mask_value),
		.beta_value(beta_value), .last_beta(last_beta), .item_valid(item_valid),
		.item_ready(item_ready), .item(item)
	);

	msrp_back #(
		.MAX_CELLS(MAX_CELLS), .MAX_LAYERS(MAX_LAYERS), .MAX_COVS(MAX_COVS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .item_valid(item_valid), .item_ready(item_ready),
		.item(item), .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.res_push(res_push), .res_full(res_full), .res(res_in)
	);

	msrp_outq u_outq (
		.clk(clk), .arst_n(arst_n), .res_push(res_push), .res_full(res_full),
		.res_in(res_in), .pop(pop), .empty(empty), .res_out(res_out)
	);

	assign out_layer = res_out.out_layer;
	assign probability = res_out.probability;
	assign no_valid = res_out.no_valid;
	assign last = res_out.last;

`ifndef SYNTHESIS
	a_no_valid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && no_valid) |-> (probability == 16'd0))
		else $error("no_valid result carries a nonzero probability");
	a_push_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_full) |=> res_push)
		else $error("result word dropped while the result queue was full");
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_ready) |=> item_valid)
		else $error("queued input word lost while the engine was busy");
`endif

endmodule

// ===== dv/msrp_checker.sv =====
`timescale 1ns / 1ps
// Checker for the masked softmax region probability core: watches the item, result
// and register channels, predicts each draw's results and compares them in order.
// Depends on msrp_pkg.
module msrp_checker import msrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  mode,
	input  logic [9:0]  cell_index,
	input  logic [1:0]  layer_index,
	input  logic [2:0]  cov_index,
	input  logic [15:0] cov_value,
	input  logic        cov_valid,
	input  logic [15:0] mask_value,
	input  logic [15:0] beta_value,
	input  logic        last_beta,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  out_layer,
	input  logic [15:0] probability,
	input  logic        no_valid,
	input  logic        last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data,
	output int          errors,
	output int          pending
);

	logic [16:0] cov_mem [0:32767];
	logic [15:0] mask_mem [0:4095];
	logic [15:0] beta_q [0:7];
	longint      lin_pred [0:1023];
	bit          cell_ok [0:1023];
	int unsigned n_cells;
	int unsigned layer_cnt;
	result_t     prob_q [$];

	function automatic longint unsigned exp_term(longint unsigned d);
		longint unsigned y, n, f, e;
		y = (d * 64'd94548) >> 16;
		n = y >> 20;
		f = (y >> 5) & 64'h7FFF;
		if (n >= 16)
			return 0;
		e = 64'd32768 - ((64'd21512 * f) >> 15) + ((64'd5128 * f * f) >> 30);
		return e >> n;
	endfunction

	task automatic predict_draw(int unsigned ncov);
		int unsigned     k, c, j;
		bit              any;
		longint          mx, w;
		longint unsigned total, masked, p;
		logic [16:0]     ent;
		result_t         r;
		for (k = 0; k < layer_cnt; k++) begin
			any = 0;
			mx = 0;
			total = 0;
			masked = 0;
			p = 0;
			for (c = 0; c < n_cells; c++) begin
				w = 0;
				cell_ok[c] = 1;
				for (j = 0; j < ncov; j++) begin
					ent = cov_mem[(c * 4 + k) * 8 + j];
					if (!ent[16])
						cell_ok[c] = 0;
					w += longint'($signed(ent[15:0])) * longint'($signed(beta_q[j]));
				end
				lin_pred[c] = w;
				if (cell_ok[c] && (!any || w > mx)) begin
					mx = w;
					any = 1;
				end
			end
			if (any) begin
				for (c = 0; c < n_cells; c++) begin
					if (cell_ok[c]) begin
						w = mx - lin_pred[c];
						total += exp_term(longint'(w));
						masked += exp_term(longint'(w)) * mask_mem[c * 4 + k];
					end
				end
				p = total != 0 ? masked / total : 0;
				if (p > 65535)
					p = 65535;
			end
			r.out_layer = k[1:0];
			r.probability = p[15:0];
			r.no_valid = !any;
			r.last = (k + 1 == layer_cnt);
			prob_q.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t      exp_r;
		int unsigned  v;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				beta_q[i] = '0;
			n_cells = 1024;
			layer_cnt = 4;
			prob_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (pop && !empty) begin
				if (prob_q.size() == 0) begin
					$display("%0t: result word with none expected: layer %0d prob %0d",
						$time, out_layer, probability);
					errors++;
				end else begin
					exp_r = prob_q.pop_front();
					if (out_layer !== exp_r.out_layer || probability !== exp_r.probability ||
						no_valid !== exp_r.no_valid || last !== exp_r.last) begin
						$display("%0t: mismatch expected layer %0d prob %0d nv %0b last %0b,",
							$time, exp_r.out_layer, exp_r.probability, exp_r.no_valid,
							exp_r.last);
						$display("    actual layer %0d prob %0d nv %0b last %0b",
							out_layer, probability, no_valid, last);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_CELLS) begin
					v = 32'(cfg_data);
					n_cells = v < 1 ? 1 : (v > 1024 ? 1024 : v);
				end else begin
					v = 32'(cfg_data[2:0]);
					layer_cnt = v < 1 ? 1 : (v > 4 ? 4 : v);
				end
			end
			if (push && !full) begin
				case (mode)
					MODE_COV:
						cov_mem[(cell_index * 4 + layer_index) * 8 + cov_index] =
							{cov_valid, cov_value};
					MODE_MASK:
						mask_mem[cell_index * 4 + layer_index] = mask_value;
					MODE_BETA: begin
						beta_q[cov_index] = beta_value;
						if (last_beta)
							predict_draw(32'(cov_index) + 1);
					end
					default: ;
				endcase
			end
			pending = prob_q.size();
		end
	end

endmodule

// ===== dv/tb_masked_softmax_region_probability_core.sv =====
`timescale 1ns / 1ps
// Testbench top for the masked softmax region probability core: drives loads, beta
// draws and register writes with random idling and gives the verdict.
// Depends on msrp_pkg, msrp_checker and the core.
module tb_masked_softmax_region_probability_core;
	import msrp_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        push = 0;
	logic        full;
	logic [1:0]  mode = MODE_NONE;
	logic [9:0]  cell_index = '0;
	logic [1:0]  layer_index = '0;
	logic [2:0]  cov_index = '0;
	logic [15:0] cov_value = '0;
	logic        cov_valid = 0;
	logic [15:0] mask_value = '0;
	logic [15:0] beta_value = '0;
	logic        last_beta = 0;
	logic        empty;
	logic        pop = 0;
	logic [1:0]  out_layer;
	logic [15:0] probability;
	logic        no_valid;
	logic        last;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic        cfg_index = CFG_CELLS;
	logic [10:0] cfg_data = '0;
	int          errors;
	int          pending;
	int          pops_done = 0;
	bit          no_idle = 0;
	int          cycles = 0;

	masked_softmax_region_probability_core u_top (.*);

	msrp_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == 2000000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_word(int m, int c, int l, int j, int cv, int vld, int mv, int bv,
			int lb);
		int  gap;
		bit  f;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		push <= 1;
		mode <= 2'(m);
		cell_index <= 10'(c);
		layer_index <= 2'(l);
		cov_index <= 3'(j);
		cov_value <= 16'(cv);
		cov_valid <= 1'(vld);
		mask_value <= 16'(mv);
		beta_value <= 16'(bv);
		last_beta <= 1'(lb);
		forever begin
			@(negedge clk);
			f = full;
			@(posedge clk);
			if (!f)
				break;
		end
	endtask

	task automatic wait_drained();
		push <= 0;
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		bit r;
		wait_drained();
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= 11'(val);
		forever begin
			@(negedge clk);
			r = cfg_ready;
			@(posedge clk);
			if (r)
				break;
		end
		cfg_valid <= 0;
	endtask

	task automatic cov_word(int c, int l, int j, int v, int vld);
		send_word(int'(MODE_COV), c, l, j, v, vld, $urandom, $urandom, 0);
	endtask

	task automatic beta_word(int j, int b, int lb);
		send_word(int'(MODE_BETA), $urandom, $urandom, j, $urandom, $urandom, $urandom, b,
			lb);
	endtask

	initial begin
		int nrand;
		int n;
		int c;
		@(posedge arst_n);
		@(posedge clk);

		for (int ci = 0; ci < 8; ci++)
			for (int l = 0; l < 4; l++) begin
				for (int j = 0; j < 8; j++)
					cov_word(ci, l, j, $urandom, int'($urandom_range(0, 15) != 0));
				send_word(int'(MODE_MASK), ci, l, $urandom, $urandom, $urandom, $urandom,
					$urandom, 0);
			end

		write_reg(CFG_CELLS, 4);
		write_reg(CFG_LAYERS, 4);
		cov_word(0, 0, 0, 'h8000, 1);
		cov_word(1, 0, 0, 'h7FFF, 1);
		send_word(int'(MODE_MASK), 0, 0, 0, 0, 0, 'hFFFF, 0, 0);
		send_word(int'(MODE_MASK), 1, 0, 0, 0, 0, 'h0000, 0, 0);
		for (int ci = 0; ci < 4; ci++)
			cov_word(ci, 3, 0, $urandom, 0);
		cov_word(2, 1, 1, 'h0100, 0);
		send_word(int'(MODE_NONE), $urandom, $urandom, $urandom, $urandom, 1, $urandom,
			$urandom, 1);
		send_word(int'(MODE_COV), 2, 2, 0, 'h0100, 1, 0, 0, 1);
		beta_word(0, 'h8000, 1);
		beta_word(7, 'h7FFF, 0);
		beta_word(3, 'h0000, 1);
		beta_word(7, 'h7FFF, 1);
		write_reg(CFG_CELLS, 0);
		write_reg(CFG_LAYERS, 0);
		beta_word(1, 'h1000, 1);
		write_reg(CFG_CELLS, 8);
		write_reg(CFG_LAYERS, 7);
		beta_word(2, 'hF000, 1);

		nrand = 0;
		while (nrand < 150) begin
			if ($urandom_range(0, 7) == 0) begin
				write_reg(CFG_CELLS, $urandom_range(0, 8));
				write_reg(CFG_LAYERS, int'(11'({$urandom_range(0, 255),
					3'($urandom_range(0, 7))})));
			end
			no_idle = $urandom_range(0, 3) == 0;
			n = $urandom_range(0, 6);
			for (int i = 0; i < n; i++) begin
				c = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 1023);
				case ($urandom_range(0, 9))
					0: send_word(int'(MODE_NONE), $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom, $urandom);
					1, 2, 3: send_word(int'(MODE_MASK), c, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom, $urandom);
					default: send_word(int'(MODE_COV), c, $urandom, $urandom, $urandom,
						int'($urandom_range(0, 9) != 0), $urandom, $urandom, $urandom);
				endcase
				nrand++;
			end
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++) begin
				beta_word($urandom_range(0, 7), $urandom, int'(i == n - 1));
				nrand++;
			end
		end
		no_idle = 0;

		wait_drained();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		int  stall;
		bit  e;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
			if (pops_done == 30)
				stall = 3000;
			if (stall > 0) begin
				pop <= 0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1;
			forever begin
				@(negedge clk);
				e = empty;
				@(posedge clk);
				if (!e)
					break;
			end
			pops_done++;
		end
	end

endmodule

// ===== sim.f =====
hw/rtl/msrp_pkg.sv
hw/rtl/msrp_front.sv
hw/rtl/msrp_outq.sv
hw/rtl/msrp_back.sv
hw/rtl/masked_softmax_region_probability_core.sv
dv/msrp_checker.sv
dv/tb_masked_softmax_region_probability_core.sv
